@@ design/tpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpu_pkg;

    localparam int MAX_CHANNELS = 32;
    localparam int MAX_ROWS     = 256;

    // Effective count limits: the position fields are five and eight bits wide.
    localparam int CH_LIMIT  = (MAX_CHANNELS > 32) ? 32 : MAX_CHANNELS;
    localparam int ROW_LIMIT = (MAX_ROWS > 256) ? 256 : MAX_ROWS;

    localparam int FIELD_COUNT = 5;
    localparam int CFG_WIDTH   = 9;

    localparam logic [7:0] KEY_OFF_IN  = 8'd97;
    localparam logic [7:0] KEY_OFF_OUT = 8'd127;

    localparam logic [5:0] CHANNEL_COUNT_RESET   = 6'd1;
    localparam logic [8:0] ROW_COUNT_RESET       = 9'd64;
    localparam logic [7:0] INSTRUMENT_BASE_RESET = 8'd0;

    typedef enum logic [1:0] {
        REG_CHANNEL_COUNT   = 2'd0,
        REG_ROW_COUNT       = 2'd1,
        REG_INSTRUMENT_BASE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] note;
        logic [8:0] instrument;
        logic [7:0] volume;
        logic [7:0] effect;
        logic [7:0] effect_param;
        logic [4:0] present_mask;
        logic [7:0] row;
        logic [4:0] channel;
        logic       last_in_pattern;
    } cell_result_t;

    // Index of the first set mask bit at or above from; FIELD_COUNT if none.
    function automatic logic [2:0] next_field(input logic [4:0] mask, input logic [2:0] from);
        logic [2:0] res;
        res = 3'(FIELD_COUNT);
        for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
            if ((3'(i) >= from) && mask[i])
            begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/tpu_byte_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tpu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

@@ design/tpu_cell_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tpu_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] note;
    logic [8:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] effect_param;
    logic [4:0] present_mask;
    logic [7:0] row;
    logic [4:0] channel;
    logic       last_in_pattern;

    modport source (
        output valid, output note, output instrument, output volume, output effect,
        output effect_param, output present_mask, output row, output channel,
        output last_in_pattern, input ready
    );
    modport sink (
        input valid, input note, input instrument, input volume, input effect,
        input effect_param, input present_mask, input row, input channel,
        input last_in_pattern, output ready
    );
endinterface

`default_nettype wire

@@ design/tracker_pattern_unpacker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Tracker pattern unpacker.
// The stream channel takes packed pattern bytes, one item per cycle. A byte
// with bit 7 set is a mask naming which of note, instrument, volume, effect
// and effect parameter follow; any other byte is the note of a full cell.
// When the last byte of a cell is accepted, one item leaves on the cells
// channel with the decoded fields, the presence mask, row, channel and an
// end-of-pattern flag, registered in the output register or the skid entry.
// Throughput is one byte per cycle; the field sequencer updates in the same
// cycle the byte is taken. The cell output has a register and one skid
// entry, so a byte is still taken while a finished cell waits; only when
// both are full does stream.ready drop until the receiver takes a cell.
// The user must write configuration (channel count, row count, instrument
// base) through cfg_wen/cfg_idx/cfg_wdata only while the block is idle; the block does not enforce it.
// Reset sets channel count 1, row count 64, base 0, and the position to
// row 0, channel 0, waiting for the start of a cell.
module tracker_pattern_unpacker #(
    parameter int MAX_CHANNELS = tpu_pkg::MAX_CHANNELS,
    parameter int MAX_ROWS     = tpu_pkg::MAX_ROWS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [1:0]                    cfg_idx,
    input  wire logic [tpu_pkg::CFG_WIDTH-1:0] cfg_wdata,
    tpu_byte_if.sink                           stream,
    tpu_cell_if.source                         cells
);

    // The position fields are five and eight bits wide.
    localparam int CH_LIMIT  = (MAX_CHANNELS > 32) ? 32 : MAX_CHANNELS;
    localparam int ROW_LIMIT = (MAX_ROWS > 256) ? 256 : MAX_ROWS;

    logic [5:0] chan_count_reg;
    logic [8:0] row_count_reg;
    logic [7:0] inst_base_reg;

    logic [2:0] phase_reg, phase_next;
    logic [4:0] pmask_reg, pmask_next;
    logic       packed_reg, packed_next;
    logic [7:0] fields_reg [tpu_pkg::FIELD_COUNT];
    logic [7:0] fields_next [tpu_pkg::FIELD_COUNT];
    logic [7:0] row_reg, row_next;
    logic [4:0] chan_reg, chan_next;

    tpu_pkg::cell_result_t out_reg, out_next;
    tpu_pkg::cell_result_t skid_reg, skid_next;
    tpu_pkg::cell_result_t res;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;

    logic       acc;
    logic       start;
    logic       emit;
    logic [7:0] b;
    logic [7:0] b_mapped;
    logic [2:0] idx;
    logic [2:0] nxt;
    logic [5:0] eff_ch;
    logic [8:0] eff_rows;
    logic       ch_last;
    logic       row_last;
    logic       take;

    assign stream.ready = !skid_valid_reg;
    assign acc          = stream.valid && stream.ready;
    assign b            = stream.data_byte;
    assign start        = (phase_reg == 3'd0) || (phase_reg > 3'(tpu_pkg::FIELD_COUNT));
    assign idx          = phase_reg - 3'd1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= tpu_pkg::CHANNEL_COUNT_RESET;
            row_count_reg  <= tpu_pkg::ROW_COUNT_RESET;
            inst_base_reg  <= tpu_pkg::INSTRUMENT_BASE_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                tpu_pkg::REG_CHANNEL_COUNT:   chan_count_reg <= cfg_wdata[5:0];
                tpu_pkg::REG_ROW_COUNT:       row_count_reg  <= cfg_wdata[8:0];
                tpu_pkg::REG_INSTRUMENT_BASE: inst_base_reg  <= cfg_wdata[7:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        if (chan_count_reg == 6'd0)
            eff_ch = 6'd1;
        else if (chan_count_reg > 6'(CH_LIMIT))
            eff_ch = 6'(CH_LIMIT);
        else
            eff_ch = chan_count_reg;

        if (row_count_reg == 9'd0)
            eff_rows = 9'd1;
        else if (row_count_reg > 9'(ROW_LIMIT))
            eff_rows = 9'(ROW_LIMIT);
        else
            eff_rows = row_count_reg;
    end

    assign ch_last  = ({2'b00, chan_reg} + 7'd1) >= {1'b0, eff_ch};
    assign row_last = ({2'b00, row_reg} + 10'd1) >= {1'b0, eff_rows};

    // Field sequencer
    always_comb
    begin
        phase_next  = phase_reg;
        pmask_next  = pmask_reg;
        packed_next = packed_reg;
        fields_next = fields_reg;
        emit        = 1'b0;
        nxt         = 3'd0;
        b_mapped    = b;

        if (start)
        begin
            for (int i = 0; i < tpu_pkg::FIELD_COUNT; i++)
            begin
                fields_next[i] = 8'd0;
            end
            if (b[7])
            begin
                packed_next = 1'b1;
                pmask_next  = b[4:0];
                nxt         = tpu_pkg::next_field(b[4:0], 3'd0);
            end
            else
            begin
                packed_next    = 1'b0;
                pmask_next     = 5'h1F;
                fields_next[0] = b;
                nxt            = 3'd1;
            end
        end
        else
        begin
            // Key off is remapped only inside packed cells.
            if ((idx == 3'd0) && packed_reg && (b == tpu_pkg::KEY_OFF_IN))
                b_mapped = tpu_pkg::KEY_OFF_OUT;
            for (int i = 0; i < tpu_pkg::FIELD_COUNT; i++)
            begin
                if (idx == 3'(i))
                    fields_next[i] = b_mapped;
            end
            nxt = tpu_pkg::next_field(pmask_reg, phase_reg);
        end

        if (nxt >= 3'(tpu_pkg::FIELD_COUNT))
        begin
            emit       = 1'b1;
            phase_next = 3'd0;
        end
        else
        begin
            phase_next = nxt + 3'd1;
        end
    end

    always_comb
    begin
        res.note            = fields_next[0];
        res.instrument      = pmask_next[1] ? ({1'b0, fields_next[1]} + {1'b0, inst_base_reg})
                                            : 9'd0;
        res.volume          = fields_next[2];
        res.effect          = fields_next[3];
        res.effect_param    = fields_next[4];
        res.present_mask    = pmask_next;
        res.row             = row_reg;
        res.channel         = chan_reg;
        res.last_in_pattern = ch_last && row_last;

        row_next  = row_reg;
        chan_next = chan_reg;
        if (emit)
        begin
            if (ch_last)
            begin
                chan_next = 5'd0;
                row_next  = row_last ? 8'd0 : row_reg + 8'd1;
            end
            else
            begin
                chan_next = chan_reg + 5'd1;
            end
        end
    end

    // Output register with one skid entry
    assign take = out_valid_reg && cells.ready;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = acc && emit;
            end
        end
        else if (acc && emit)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 3'd0;
            pmask_reg      <= 5'd0;
            packed_reg     <= 1'b0;
            row_reg        <= 8'd0;
            chan_reg       <= 5'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg  <= phase_next;
                pmask_reg  <= pmask_next;
                packed_reg <= packed_next;
                row_reg    <= row_next;
                chan_reg   <= chan_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            fields_reg <= fields_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign cells.valid           = out_valid_reg;
    assign cells.note            = out_reg.note;
    assign cells.instrument      = out_reg.instrument;
    assign cells.volume          = out_reg.volume;
    assign cells.effect          = out_reg.effect;
    assign cells.effect_param    = out_reg.effect_param;
    assign cells.present_mask    = out_reg.present_mask;
    assign cells.row             = out_reg.row;
    assign cells.channel         = out_reg.channel;
    assign cells.last_in_pattern = out_reg.last_in_pattern;

    // The skid entry is only ever filled behind a waiting output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a cell while the output register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= 3'(tpu_pkg::FIELD_COUNT))
        else $error("field phase out of range");

    // An empty mask byte completes a cell at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && start && b[7] && (b[4:0] == 5'd0)) |=> out_valid_reg)
        else $error("empty mask byte did not produce a cell");

    // A plain byte starts a full cell and moves on to the instrument.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && start && !b[7]) |=> (phase_reg == 3'd2) && (pmask_reg == 5'h1F))
        else $error("unpacked cell start did not advance to the instrument");

endmodule

`default_nettype wire
